// ===== hdl/bqs_pkg.sv =====
// Shared types and constants for the biquad filter with level statistics.
// Used by bqs_regs, bqs_ctrl, bqs_dp and the top level; no dependencies.
package bqs_pkg;

    localparam int COEF_WIDTH            = 16;
    localparam int DELAY_WIDTH           = 32;
    localparam int SUM_WIDTH             = 48;
    localparam int SAMPLE_WIDTH_DEFAULT  = 16;
    localparam int COEF_FRAC_BITS_DEFAULT = 14;
    localparam int COUNT_WIDTH_DEFAULT   = 32;
    localparam int APB_ADDR_WIDTH        = 5;
    localparam int APB_DATA_WIDTH        = 32;

    typedef enum logic [1:0] {
        MODE_FILTER = 2'd0,
        MODE_MEAN   = 2'd1,
        MODE_PEAK   = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_A1 = 3'd0,
        REG_A2 = 3'd1,
        REG_B0 = 3'd2,
        REG_B1 = 3'd3,
        REG_B2 = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
        logic signed [COEF_WIDTH-1:0] b0;
        logic signed [COEF_WIDTH-1:0] b1;
        logic signed [COEF_WIDTH-1:0] b2;
    } coef_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_F4,
        ST_F5,
        ST_RND,
        ST_DIV,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FILT_START,
        OP_FILT_1,
        OP_FILT_2,
        OP_FILT_3,
        OP_FILT_4,
        OP_FILT_5,
        OP_FILT_RND,
        OP_DIV_START,
        OP_DIV_STEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   finish;
        mode_t  fin_mode;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic count_zero;
    } dp_status_t;

endpackage

// ===== hdl/biquad_filter_with_level_stats.sv =====
// Top level of the biquad IIR filter with output level statistics.
// Depends on bqs_pkg, bqs_regs, bqs_ctrl and bqs_dp.
//
// Usage:
//   Coefficients a1, a2, b0, b1, b2 (Q2.14) are written over the APB port at
//   byte addresses 0, 4, 8, 12, 16; pready is always high, reads return the
//   sign-extended coefficient. Each input transaction (mode, sample) gives
//   exactly one output transaction (value, saturated).
//   mode 0 filters one sample; mode 1 returns the mean absolute output and
//   clears sum and count (0 if no samples); mode 2 returns the peak absolute
//   output and clears it; mode 3 clears the filter delays and returns 0.
//   One transaction is processed at a time. A filter sample reaches the
//   output register after five products through one shared 16x32
//   multiplier, a rounding and saturation step, then the statistics
//   update. A mean read runs a 48-step bit-serial divide, skipped when
//   the count is zero; peak and clear reads go straight to the commit
//   state. The input is ready again the cycle after the result is
//   registered. The result sits in an output register; if the receiver
//   stalls, the next transaction is accepted and computed, and waits in
//   its commit state until the output register is taken.
//   Reset clears the coefficients, the delays and all statistics.
module biquad_filter_with_level_stats #(
    parameter int SAMPLE_WIDTH   = bqs_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int COEF_FRAC_BITS = bqs_pkg::COEF_FRAC_BITS_DEFAULT,
    parameter int COUNT_WIDTH    = bqs_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bqs_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [bqs_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [bqs_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         mode,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]     value,
    output logic                               saturated
);
    import bqs_pkg::*;

    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    coef_t      coef;
    dp_cmd_t    cmd;
    dp_status_t status;

    bqs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    bqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode_t'(mode)),
        .status   (status),
        .cmd      (cmd)
    );

    bqs_dp #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .coef      (coef),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .saturated (saturated)
    );

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input accepted while a transaction is in flight");

    a_result_from_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready)
    ) else $error("result produced without a transaction in flight");

    a_clip_at_rail: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (value == Y_MAX || value == Y_MIN)
    ) else $error("saturated result not at a rail");

endmodule

// ===== hdl/bqs_regs.sv =====
// APB coefficient register file for the biquad filter.
// Depends on bqs_pkg.
module bqs_regs (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [bqs_pkg::APB_ADDR_WIDTH-1:0]     paddr,
    input  logic [bqs_pkg::APB_DATA_WIDTH-1:0]     pwdata,
    output logic [bqs_pkg::APB_DATA_WIDTH-1:0]     prdata,
    output logic                                   pready,
    output bqs_pkg::coef_t                         coef
);
    import bqs_pkg::*;

    coef_t                        coef_reg;
    coef_t                        coef_next;
    reg_idx_t                     idx;
    logic                         wr_en;
    logic signed [COEF_WIDTH-1:0] wr_val;
    logic signed [COEF_WIDTH-1:0] rd_coef;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_WIDTH-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_val = pwdata[COEF_WIDTH-1:0];
    assign pready = 1'b1;

    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_A1:  coef_next.a1 = wr_val;
                REG_A2:  coef_next.a2 = wr_val;
                REG_B0:  coef_next.b0 = wr_val;
                REG_B1:  coef_next.b1 = wr_val;
                REG_B2:  coef_next.b2 = wr_val;
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_A1:  rd_coef = coef_reg.a1;
            REG_A2:  rd_coef = coef_reg.a2;
            REG_B0:  rd_coef = coef_reg.b0;
            REG_B1:  rd_coef = coef_reg.b1;
            REG_B2:  rd_coef = coef_reg.b2;
            default: rd_coef = '0;
        endcase
    end

    assign prdata = APB_DATA_WIDTH'(rd_coef);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

// ===== hdl/bqs_ctrl.sv =====
// Sequencing state machine for the biquad filter: steps the shared
// multiplier, the mean divider and the result commit. Depends on bqs_pkg.
module bqs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bqs_pkg::mode_t      mode,
    input  bqs_pkg::dp_status_t status,
    output bqs_pkg::dp_cmd_t    cmd
);
    import bqs_pkg::*;

    localparam int CNT_W = $clog2(SUM_WIDTH);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SUM_WIDTH - 1);

    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    mode_t             mode_reg;
    mode_t             mode_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_FILTER: state_next = ST_F1;
                        MODE_MEAN:   state_next = status.count_zero ? ST_DONE : ST_DIV;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_F1:  state_next = ST_F2;
            ST_F2:  state_next = ST_F3;
            ST_F3:  state_next = ST_F4;
            ST_F4:  state_next = ST_F5;
            ST_F5:  state_next = ST_RND;
            ST_RND: state_next = ST_DONE;
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op       = OP_NOP;
        cmd.finish   = 1'b0;
        cmd.fin_mode = mode_reg;
        mode_next    = mode_reg;
        cnt_next     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = mode;
                    unique case (mode)
                        MODE_FILTER: cmd.op = OP_FILT_START;
                        MODE_MEAN:   cmd.op = status.count_zero ? OP_NOP : OP_DIV_START;
                        default:     cmd.op = OP_NOP;
                    endcase
                end
            end
            ST_F1:  cmd.op = OP_FILT_1;
            ST_F2:  cmd.op = OP_FILT_2;
            ST_F3:  cmd.op = OP_FILT_3;
            ST_F4:  cmd.op = OP_FILT_4;
            ST_F5:  cmd.op = OP_FILT_5;
            ST_RND: cmd.op = OP_FILT_RND;
            ST_DIV:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_DONE: cmd.finish = status.out_free;
            default: cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_FILTER;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== hdl/bqs_dp.sv =====
// Datapath of the biquad filter: shared 16x32 multiplier, accumulator,
// rounding and saturation, level statistics, radix-2 divider and output
// register. Depends on bqs_pkg.
module bqs_dp #(
    parameter int SAMPLE_WIDTH   = bqs_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int COEF_FRAC_BITS = bqs_pkg::COEF_FRAC_BITS_DEFAULT,
    parameter int COUNT_WIDTH    = bqs_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bqs_pkg::dp_cmd_t               cmd,
    output bqs_pkg::dp_status_t            status,
    input  bqs_pkg::coef_t                 coef,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] value,
    output logic                           saturated
);
    import bqs_pkg::*;

    localparam int PROD_W = COEF_WIDTH + DELAY_WIDTH;
    localparam int X_W    = SAMPLE_WIDTH + COEF_FRAC_BITS;
    localparam int ACC_W  = ((X_W > PROD_W) ? X_W : PROD_W) + 3;
    localparam int MAG_W  = SAMPLE_WIDTH - 1;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [DELAY_WIDTH-1:0] D_MAX = {1'b0, {(DELAY_WIDTH-1){1'b1}}};
    localparam logic signed [DELAY_WIDTH-1:0] D_MIN = {1'b1, {(DELAY_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // architectural state
    logic signed [DELAY_WIDTH-1:0]  delay_one_reg, delay_one_next;
    logic signed [DELAY_WIDTH-1:0]  delay_two_reg, delay_two_next;
    logic [SUM_WIDTH-1:0]           sum_reg, sum_next;
    logic [COUNT_WIDTH-1:0]         count_reg, count_next;
    logic [MAG_W-1:0]               peak_reg, peak_next;
    logic                           out_valid_reg, out_valid_next;

    // working registers
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [DELAY_WIDTH-1:0]  w0_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic                           clip_reg;
    logic [COUNT_WIDTH-1:0]         rem_reg, rem_next;
    logic [SUM_WIDTH-1:0]           quo_reg, quo_next;
    logic signed [SAMPLE_WIDTH-1:0] value_reg, value_next;
    logic                           saturated_reg, saturated_next;

    logic signed [COEF_WIDTH-1:0]   mul_a;
    logic signed [DELAY_WIDTH-1:0]  mul_b;
    logic signed [PROD_W-1:0]       prod_full;
    logic signed [ACC_W-1:0]        prod_ext;
    logic signed [ACC_W-1:0]        acc_rnd;
    logic [ACC_W-DELAY_WIDTH:0]     w0_hi;
    logic [ACC_W-SAMPLE_WIDTH:0]    y_hi;
    logic signed [DELAY_WIDTH-1:0]  w0_sat;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic                           y_clip;
    logic [SAMPLE_WIDTH-1:0]        y_neg;
    logic [SAMPLE_WIDTH-1:0]        mag_full;
    logic [MAG_W-1:0]               mag;
    logic [SUM_WIDTH:0]             sum_inc;
    logic [COUNT_WIDTH:0]           div_shift;
    logic [COUNT_WIDTH+1:0]         div_diff;

    always_comb
    begin
        unique case (cmd.op)
            OP_FILT_1:
            begin
                mul_a = coef.a2;
                mul_b = delay_two_reg;
            end
            OP_FILT_2:
            begin
                mul_a = coef.b1;
                mul_b = delay_one_reg;
            end
            OP_FILT_3:
            begin
                mul_a = coef.b2;
                mul_b = delay_two_reg;
            end
            OP_FILT_4:
            begin
                mul_a = coef.b0;
                mul_b = w0_reg;
            end
            default:
            begin
                mul_a = coef.a1;
                mul_b = delay_one_reg;
            end
        endcase
    end

    assign prod_full = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_ext  = ACC_W'(prod_reg);
    assign acc_rnd   = (acc_reg + RND_HALF) >>> COEF_FRAC_BITS;

    assign w0_hi  = acc_rnd[ACC_W-1:DELAY_WIDTH-1];
    assign w0_sat = ((&w0_hi) || !(|w0_hi)) ? acc_rnd[DELAY_WIDTH-1:0]
                  : (acc_rnd[ACC_W-1] ? D_MIN : D_MAX);
    assign y_hi   = acc_rnd[ACC_W-1:SAMPLE_WIDTH-1];
    assign y_clip = !((&y_hi) || !(|y_hi));
    assign y_sat  = !y_clip ? acc_rnd[SAMPLE_WIDTH-1:0]
                  : (acc_rnd[ACC_W-1] ? Y_MIN : Y_MAX);

    // |y|, with the most negative value clipped to the largest positive one
    assign y_neg    = -y_reg;
    assign mag_full = y_reg[SAMPLE_WIDTH-1] ? y_neg : y_reg;
    assign mag      = mag_full[SAMPLE_WIDTH-1] ? {MAG_W{1'b1}} : mag_full[MAG_W-1:0];
    assign sum_inc  = {1'b0, sum_reg} + (SUM_WIDTH+1)'(mag);

    assign div_shift = {rem_reg, quo_reg[SUM_WIDTH-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, count_reg};

    always_comb
    begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        case (cmd.op)
            OP_FILT_START: acc_next = ACC_W'(sample) <<< COEF_FRAC_BITS;
            OP_FILT_1:     acc_next = acc_reg - prod_ext;
            OP_FILT_2:     acc_next = acc_reg - prod_ext;
            OP_FILT_3:     acc_next = prod_ext;
            OP_FILT_4:     acc_next = acc_reg + prod_ext;
            OP_FILT_5:     acc_next = acc_reg + prod_ext;
            OP_DIV_START:
            begin
                rem_next = '0;
                quo_next = sum_reg;
            end
            OP_DIV_STEP:
            begin
                if (!div_diff[COUNT_WIDTH+1])
                begin
                    rem_next = div_diff[COUNT_WIDTH-1:0];
                    quo_next = {quo_reg[SUM_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_shift[COUNT_WIDTH-1:0];
                    quo_next = {quo_reg[SUM_WIDTH-2:0], 1'b0};
                end
            end
            default: acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        delay_one_next = delay_one_reg;
        delay_two_next = delay_two_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        peak_next      = peak_reg;
        value_next     = value_reg;
        saturated_next = saturated_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            saturated_next = 1'b0;
            unique case (cmd.fin_mode)
                MODE_FILTER:
                begin
                    value_next     = y_reg;
                    saturated_next = clip_reg;
                    delay_two_next = delay_one_reg;
                    delay_one_next = w0_reg;
                    sum_next       = sum_inc[SUM_WIDTH] ? {SUM_WIDTH{1'b1}}
                                                        : sum_inc[SUM_WIDTH-1:0];
                    count_next     = (&count_reg) ? count_reg
                                                  : count_reg + COUNT_WIDTH'(1);
                    if (mag > peak_reg)
                    begin
                        peak_next = mag;
                    end
                end
                MODE_MEAN:
                begin
                    value_next = (count_reg == '0) ? '0 : quo_reg[SAMPLE_WIDTH-1:0];
                    sum_next   = '0;
                    count_next = '0;
                end
                MODE_PEAK:
                begin
                    value_next = SAMPLE_WIDTH'(peak_reg);
                    peak_next  = '0;
                end
                MODE_CLEAR:
                begin
                    value_next     = '0;
                    delay_one_next = '0;
                    delay_two_next = '0;
                end
                default: value_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_one_reg <= '0;
            delay_two_reg <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            delay_one_reg <= delay_one_next;
            delay_two_reg <= delay_two_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_full;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        value_reg     <= value_next;
        saturated_reg <= saturated_next;
        if (cmd.op == OP_FILT_3)
        begin
            w0_reg <= w0_sat;
        end
    end

    // acc holds the full feedforward sum during the rounding step
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FILT_RND)
        begin
            y_reg    <= y_sat;
            clip_reg <= y_clip;
        end
    end

    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.count_zero = (count_reg == '0);
    assign out_valid         = out_valid_reg;
    assign value             = value_reg;
    assign saturated         = saturated_reg;

endmodule
